// ===== rtl/lzss_decompressor_unit_defines.svh =====
`ifndef LZSS_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZSS_DECOMPRESSOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the block clock and held off during reset.
`define LZSS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the block clock and held off during reset.
`define LZSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/lzss_pkg.sv =====
package lzss_pkg;

   localparam int WINDOW_BITS = 12;
   localparam int COUNT_BITS  = 24;
   localparam int LEN_BITS    = 24;
   localparam int CMP_BITS    = 33;
   localparam int REMAIN_BITS = 5;

   localparam logic [WINDOW_BITS-1:0] RING_BIAS = WINDOW_BITS'('h12);
   localparam logic [REMAIN_BITS-1:0] MIN_MATCH = REMAIN_BITS'(3);
   localparam logic [WINDOW_BITS:0]   FULL_DIST = {1'b1, {WINDOW_BITS{1'b0}}};

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       last;
      logic       error;
   } emit_type;

   typedef struct packed {
      logic                   wr_en;
      logic [WINDOW_BITS-1:0] wr_addr;
      logic [7:0]             wr_data;
      logic                   rd_en;
      logic [WINDOW_BITS-1:0] rd_addr;
   } ram_req_type;

endpackage

// ===== rtl/lzss_history_ram.sv =====
module lzss_history_ram #(
   parameter int ADDR_BITS = 12,
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem_ff [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lzss_rsp_stage.sv =====
module lzss_rsp_stage
   import lzss_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  emit_type   emit,
   input  logic       rsp_stall,
   output logic       out_free,
   output logic       rsp_valid,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last,
   output logic       rsp_error
);

   logic     valid_ff;
   logic     valid_in;
   emit_type hold_ff;

   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = out_free ? emit.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit.valid) begin
         hold_ff <= emit;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_data_byte = hold_ff.data_byte;
   assign rsp_last      = hold_ff.last;
   assign rsp_error     = hold_ff.error;

endmodule

// ===== rtl/lzss_token_ctrl.sv =====
module lzss_token_ctrl
   import lzss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [7:0]          req_code_byte,
   input  logic                req_first,
   output logic                req_stall,
   input  logic                csr_valid,
   input  logic [LEN_BITS-1:0] csr_output_length,
   input  logic                out_free,
   output emit_type            emit,
   output ram_req_type         ram_req,
   input  logic [7:0]          ram_q
);

   localparam logic [1:0] PH_FLAG  = 2'd0;
   localparam logic [1:0] PH_TOKEN = 2'd1;
   localparam logic [1:0] PH_HIGH  = 2'd2;

   logic [COUNT_BITS-1:0]  out_count_ff, out_count_in;
   logic [1:0]             phase_ff, phase_in;
   logic [7:0]             flag_bits_ff, flag_bits_in;
   logic [2:0]             token_index_ff, token_index_in;
   logic [7:0]             match_low_ff, match_low_in;
   logic                   finished_ff, finished_in;
   logic [LEN_BITS-1:0]    length_ff, length_in;
   logic                   copy_ff, copy_in;
   logic [WINDOW_BITS-1:0] src_ff, src_in;
   logic [REMAIN_BITS-1:0] remain_ff, remain_in;
   logic                   fwd_ff, fwd_in;
   logic [7:0]             fwd_data_ff, fwd_data_in;

   logic                   accept;
   logic [COUNT_BITS-1:0]  cnt;
   logic [COUNT_BITS-1:0]  cnt_inc;
   logic [1:0]             ph;
   logic [2:0]             tok;
   logic [2:0]             tok_inc;
   logic                   fin;
   logic                   at_end;
   logic                   do_emit;
   logic [7:0]             em_data;
   logic [WINDOW_BITS-1:0] pos;
   logic [WINDOW_BITS-1:0] dist_low;
   logic [WINDOW_BITS:0]   back_dist;
   logic [WINDOW_BITS-1:0] src_start;
   logic [REMAIN_BITS-1:0] remain_dec;

   assign req_stall = copy_ff || !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      out_count_in   = out_count_ff;
      phase_in       = phase_ff;
      flag_bits_in   = flag_bits_ff;
      token_index_in = token_index_ff;
      match_low_in   = match_low_ff;
      finished_in    = finished_ff;
      length_in      = csr_valid ? csr_output_length : length_ff;
      copy_in        = copy_ff;
      src_in         = src_ff;
      remain_in      = remain_ff;
      emit           = '0;
      ram_req        = '0;
      do_emit        = 1'b0;
      em_data        = req_code_byte;

      // A first byte restarts the entry before it is decoded.
      cnt = out_count_ff;
      ph  = phase_ff;
      tok = token_index_ff;
      fin = finished_ff;
      if (accept && req_first) begin
         cnt = '0;
         ph  = PH_FLAG;
         tok = '0;
         fin = (length_ff == '0);
      end

      cnt_inc    = cnt + COUNT_BITS'(1);
      at_end     = CMP_BITS'(cnt_inc) >= CMP_BITS'(length_ff);
      tok_inc    = tok + 3'd1;
      pos        = {req_code_byte[7:4], match_low_ff};
      src_start  = pos + RING_BIAS;
      dist_low   = cnt[WINDOW_BITS-1:0] - src_start;
      back_dist  = (dist_low == '0) ? FULL_DIST : {1'b0, dist_low};
      remain_dec = remain_ff - REMAIN_BITS'(1);

      if (accept) begin
         out_count_in   = cnt;
         phase_in       = ph;
         token_index_in = tok;
         finished_in    = fin;
         if (!fin) begin
            unique case (ph)
               PH_TOKEN: begin
                  if (flag_bits_ff[tok]) begin
                     do_emit        = 1'b1;
                     token_index_in = tok_inc;
                     phase_in       = (tok_inc == '0) ? PH_FLAG : PH_TOKEN;
                  end else begin
                     match_low_in = req_code_byte;
                     phase_in     = PH_HIGH;
                  end
               end
               PH_HIGH: begin
                  token_index_in = tok_inc;
                  phase_in       = (tok_inc == '0) ? PH_FLAG : PH_TOKEN;
                  if (CMP_BITS'(cnt) < CMP_BITS'(back_dist)) begin
                     // Reference before the start of the output.
                     finished_in = 1'b1;
                     emit.valid  = 1'b1;
                     emit.last   = 1'b1;
                     emit.error  = 1'b1;
                  end else begin
                     copy_in         = 1'b1;
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = src_start;
                     src_in          = src_start + WINDOW_BITS'(1);
                     remain_in       = REMAIN_BITS'(req_code_byte[3:0]) + MIN_MATCH;
                  end
               end
               default: begin
                  flag_bits_in   = req_code_byte;
                  token_index_in = '0;
                  phase_in       = PH_TOKEN;
               end
            endcase
         end
      end else if (copy_ff && out_free) begin
         do_emit   = 1'b1;
         em_data   = fwd_ff ? fwd_data_ff : ram_q;
         remain_in = remain_dec;
         if (at_end || remain_dec == '0) begin
            copy_in = 1'b0;
         end else begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = src_ff;
            src_in          = src_ff + WINDOW_BITS'(1);
         end
      end

      if (do_emit) begin
         ram_req.wr_en   = 1'b1;
         ram_req.wr_addr = cnt[WINDOW_BITS-1:0];
         ram_req.wr_data = em_data;
         out_count_in    = cnt_inc;
         if (at_end) begin
            finished_in = 1'b1;
         end
         emit.valid     = 1'b1;
         emit.data_byte = em_data;
         emit.last      = at_end;
      end

      // A read of the entry written in the same cycle returns stale data, so the new
      // byte is carried alongside the read.
      fwd_in      = fwd_ff;
      fwd_data_in = fwd_data_ff;
      if (ram_req.rd_en) begin
         fwd_in      = ram_req.wr_en && (ram_req.wr_addr == ram_req.rd_addr);
         fwd_data_in = ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_count_ff   <= '0;
         phase_ff       <= PH_FLAG;
         flag_bits_ff   <= '0;
         token_index_ff <= '0;
         match_low_ff   <= '0;
         finished_ff    <= 1'b0;
         length_ff      <= '0;
         copy_ff        <= 1'b0;
         fwd_ff         <= 1'b0;
      end else begin
         out_count_ff   <= out_count_in;
         phase_ff       <= phase_in;
         flag_bits_ff   <= flag_bits_in;
         token_index_ff <= token_index_in;
         match_low_ff   <= match_low_in;
         finished_ff    <= finished_in;
         length_ff      <= length_in;
         copy_ff        <= copy_in;
         fwd_ff         <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      remain_ff   <= remain_in;
      fwd_data_ff <= fwd_data_in;
   end

endmodule

// ===== rtl/lzss_decompressor_unit.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_code_byte, req_first
// rsp_      out        rsp_valid/rsp_stall  rsp_data_byte, rsp_last, rsp_error
// csr_      in         csr_valid/csr_ready  csr_output_length
//
// Flag bytes, literals and the low byte of a match are decoded as they are accepted.
// The second byte of a match starts a copy of 3 to 18 bytes from the history memory, one
// byte per cycle unless stalled, after a registered read; requests are stalled until it ends.
// Synchronous reset clears the counters and decoder phase; the history memory is not cleared.
// A stalled result holds the output register, the copy and the request channel.
module lzss_decompressor_unit
   import lzss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_code_byte,
   input  logic                req_first,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_data_byte,
   output logic                rsp_last,
   output logic                rsp_error,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LEN_BITS-1:0] csr_output_length
);

   emit_type    emit;
   ram_req_type ram_req;
   logic [7:0]  ram_q;
   logic        out_free;

   assign csr_ready = 1'b1;

   lzss_token_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_code_byte     (req_code_byte),
      .req_first         (req_first),
      .req_stall         (req_stall),
      .csr_valid         (csr_valid),
      .csr_output_length (csr_output_length),
      .out_free          (out_free),
      .emit              (emit),
      .ram_req           (ram_req),
      .ram_q             (ram_q)
   );

   lzss_history_ram #(
      .ADDR_BITS (WINDOW_BITS),
      .DATA_BITS (8)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_q)
   );

   lzss_rsp_stage u_rsp (
      .clock         (clock),
      .reset         (reset),
      .emit          (emit),
      .rsp_stall     (rsp_stall),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_data_byte (rsp_data_byte),
      .rsp_last      (rsp_last),
      .rsp_error     (rsp_error)
   );

endmodule

// ===== rtl/lzss_checker.sv =====
`include "lzss_decompressor_unit_defines.svh"

module lzss_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_last,
   input logic       rsp_error
);

   logic       rsp_held;
   logic       err_closed;
   logic [9:0] rsp_word;

   assign rsp_held   = rsp_valid && rsp_stall;
   assign err_closed = rsp_last && (rsp_data_byte == 8'd0);
   assign rsp_word   = {rsp_data_byte, rsp_last, rsp_error};

   // An error result always closes the entry and carries a zero byte.
   `LZSS_ASSERT_NOW(a_error_closes, rsp_valid && rsp_error, err_closed, "error result open")

   // A stalled result stays in place.
   `LZSS_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_word), "result moved")

   // No request is taken while the output register is full and blocked.
   `LZSS_ASSERT_NOW(a_no_accept_full, rsp_held, req_stall, "request taken while blocked")

   // A new result follows a taken request or comes from a copy that holds the request channel.
   `LZSS_ASSERT_NOW(a_rsp_cause, $rose(rsp_valid), $past(req_valid || req_stall), "no cause")

endmodule

bind lzss_decompressor_unit lzss_checker u_checker (.*);

// ===== verif/lzss_decompressor_unit_checker.sv =====
module lzss_decompressor_unit_checker
   import lzss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [7:0]          req_code_byte,
   input  logic                req_first,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [7:0]          rsp_data_byte,
   input  logic                rsp_last,
   input  logic                rsp_error,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [LEN_BITS-1:0] csr_output_length,
   output int                  mismatch_count,
   output int                  bytes_due,
   output int                  bytes_seen
);

   localparam int RING_DEPTH = 1 << WINDOW_BITS;

   typedef enum logic [1:0] {
      WANT_FLAGS,
      WANT_TOKEN,
      WANT_POS_HIGH
   } decode_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
      logic       error;
   } out_byte_type;

   logic [7:0]            ring_mem [RING_DEPTH];
   logic [COUNT_BITS-1:0] produced;
   logic [LEN_BITS-1:0]   length_limit;
   decode_state_type      decode_state;
   logic [7:0]            flag_reg;
   logic [2:0]            token_slot;
   logic [7:0]            pos_low;
   logic                  entry_closed;
   out_byte_type          decoded_bytes [$];
   out_byte_type          want;

   function automatic void append_byte(input logic [7:0] value);
      logic at_end;
      ring_mem[produced[WINDOW_BITS-1:0]] = value;
      produced = produced + 1'b1;
      at_end = (produced >= length_limit);
      if (at_end) begin
         entry_closed = 1'b1;
      end
      decoded_bytes.insert(decoded_bytes.size(), out_byte_type'{value, at_end, 1'b0});
   endfunction

   function automatic void advance_slot();
      token_slot = token_slot + 1'b1;
      decode_state = (token_slot == '0) ? WANT_FLAGS : WANT_TOKEN;
   endfunction

   function automatic void decode_code_byte(input logic [7:0] code, input logic first);
      logic [WINDOW_BITS-1:0] pos;
      logic [WINDOW_BITS-1:0] ring_gap;
      logic [WINDOW_BITS:0]   distance;
      logic [4:0]             copy_len;
      logic [COUNT_BITS-1:0]  src;
      int                     i;
      if (first) begin
         produced = '0;
         decode_state = WANT_FLAGS;
         token_slot = '0;
         entry_closed = (length_limit == '0);
      end
      if (entry_closed) begin
         return;
      end
      case (decode_state)
         WANT_TOKEN: begin
            if (flag_reg[token_slot]) begin
               append_byte(code);
               advance_slot();
            end else begin
               pos_low = code;
               decode_state = WANT_POS_HIGH;
            end
         end
         WANT_POS_HIGH: begin
            pos = {code[7:4], pos_low};
            copy_len = code[3:0] + MIN_MATCH;
            // The ring position is biased against the output count; a gap of zero
            // means the whole window back.
            ring_gap = produced[WINDOW_BITS-1:0] - pos - RING_BIAS;
            distance = (ring_gap == '0) ? FULL_DIST : {1'b0, ring_gap};
            advance_slot();
            if (produced < distance) begin
               entry_closed = 1'b1;
               decoded_bytes.insert(decoded_bytes.size(), out_byte_type'{8'h00, 1'b1, 1'b1});
            end else begin
               src = produced - distance;
               for (i = 0; i < copy_len && !entry_closed; i++) begin
                  append_byte(ring_mem[src[WINDOW_BITS-1:0]]);
                  src = src + 1'b1;
               end
            end
         end
         default: begin
            flag_reg = code;
            token_slot = '0;
            decode_state = WANT_TOKEN;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         produced = '0;
         length_limit = '0;
         decode_state = WANT_FLAGS;
         flag_reg = '0;
         token_slot = '0;
         pos_low = '0;
         entry_closed = 1'b0;
         decoded_bytes.delete();
         mismatch_count = 0;
         bytes_seen = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            length_limit = csr_output_length;
         end
         if (req_valid && !req_stall) begin
            decode_code_byte(req_code_byte, req_first);
         end
         if (rsp_valid && !rsp_stall) begin
            bytes_seen++;
            if (decoded_bytes.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with nothing expected: data_byte=%02h last=%0b error=%0b",
                        $time, rsp_data_byte, rsp_last, rsp_error);
            end else begin
               want = decoded_bytes.pop_front();
               if (want.data_byte !== rsp_data_byte || want.last !== rsp_last ||
                   want.error !== rsp_error) begin
                  mismatch_count++;
                  $display("%0t: result mismatch: expected data_byte=%02h last=%0b error=%0b,",
                           $time, want.data_byte, want.last, want.error);
                  $display("   got data_byte=%02h last=%0b error=%0b",
                           rsp_data_byte, rsp_last, rsp_error);
               end
            end
         end
      end
      bytes_due = decoded_bytes.size();
   end

endmodule

// ===== verif/lzss_decompressor_unit_test.sv =====
module lzss_decompressor_unit_test
   import lzss_pkg::*;
();

   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 180;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [7:0]          req_code_byte;
   logic                req_first;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [7:0]          rsp_data_byte;
   logic                rsp_last;
   logic                rsp_error;
   logic                csr_valid;
   logic                csr_ready;
   logic [LEN_BITS-1:0] csr_output_length;

   int mismatch_count;
   int bytes_due;
   int bytes_seen;

   int                  gap_pct;
   int                  stall_pct;
   int                  stream_bytes;
   int                  entry_starts;
   int                  widest_reach;
   int                  gen_count;
   logic [LEN_BITS-1:0] gen_len;

   lzss_decompressor_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_code_byte     (req_code_byte),
      .req_first         (req_first),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last          (rsp_last),
      .rsp_error         (rsp_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_output_length (csr_output_length)
   );

   lzss_decompressor_unit_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_code_byte     (req_code_byte),
      .req_first         (req_first),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_last          (rsp_last),
      .rsp_error         (rsp_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_output_length (csr_output_length),
      .mismatch_count    (mismatch_count),
      .bytes_due         (bytes_due),
      .bytes_seen        (bytes_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Starts and ends on a falling edge. The request is left raised after acceptance so
   // that a following request can keep it high without a glitch.
   task automatic send_byte(input logic [7:0] code, input logic first);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         req_code_byte <= 8'($urandom);
         req_first <= 1'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_code_byte <= code;
      req_first <= first;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      stream_bytes++;
      if (first) begin
         entry_starts++;
      end
   endtask

   task automatic settle();
      while (bytes_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_length(input logic [LEN_BITS-1:0] value);
      req_valid <= 1'b0;
      settle();
      csr_valid <= 1'b1;
      csr_output_length <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      gen_len = value;
   endtask

   function automatic logic [15:0] match_token(input int count, input int back_dist,
                                               input int len);
      logic [WINDOW_BITS-1:0] pos;
      pos = WINDOW_BITS'(count - back_dist - int'(RING_BIAS));
      return {pos[7:0], pos[11:8], 4'(len - 3)};
   endfunction

   // One entry of well-formed flag groups with random content. References mostly
   // point into what has been produced so far; a few reach before the start.
   task automatic send_entry(input int groups, input int bad_pct, input int lit_pct,
                             input int full_len_pct);
      logic [7:0]  flag;
      logic [15:0] tok;
      int          g, t, len, back_dist, avail, pick;
      bit          ended;
      gen_count = 0;
      ended = (gen_len == '0);
      for (g = 0; g < groups && !(ended && g > 0); g++) begin
         for (t = 0; t < 8; t++) begin
            flag[t] = ($urandom_range(99) < lit_pct);
         end
         send_byte(flag, g == 0);
         for (t = 0; t < 8 && !ended; t++) begin
            if (flag[t]) begin
               send_byte(8'($urandom), 1'b0);
               gen_count++;
            end else begin
               len = ($urandom_range(99) < full_len_pct) ? 18 : $urandom_range(3, 18);
               avail = (gen_count > 4096) ? 4096 : gen_count;
               if (avail == 0 || (gen_count < 4096 && $urandom_range(99) < bad_pct)) begin
                  back_dist = $urandom_range(gen_count + 1, 4096);
                  ended = 1'b1;
               end else begin
                  pick = $urandom_range(99);
                  if (pick < 15) begin
                     back_dist = avail;
                  end else if (pick < 60) begin
                     back_dist = $urandom_range(1, (avail < 20) ? avail : 20);
                  end else begin
                     back_dist = $urandom_range(1, avail);
                  end
                  gen_count += len;
                  if (back_dist > widest_reach) begin
                     widest_reach = back_dist;
                  end
               end
               tok = match_token(gen_count - ((ended) ? 0 : len), back_dist, len);
               send_byte(tok[15:8], 1'b0);
               send_byte(tok[7:0], 1'b0);
            end
            if (gen_count >= gen_len) begin
               ended = 1'b1;
            end
         end
      end
   endtask

   initial begin
      logic [15:0]         tok;
      logic [LEN_BITS-1:0] new_len;
      int                  p, mark, pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_code_byte = '0;
      req_first = 1'b0;
      csr_valid = 1'b0;
      csr_output_length = '0;
      gap_pct = 0;
      stall_pct = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // A zero length entry gives nothing back, not even for its later bytes.
      write_length('0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);

      // A reference a whole window back before anything is produced is an error,
      // and the entry is closed until the next first byte.
      write_length(24'd20);
      send_byte(8'h00, 1'b1);
      tok = match_token(0, 4096, 3);
      send_byte(tok[15:8], 1'b0);
      send_byte(tok[7:0], 1'b0);
      send_byte(8'hFF, 1'b0);

      // Overlapping copy of the longest length, then a literal that ends the entry.
      send_byte(8'hFD, 1'b1);
      send_byte(8'hFF, 1'b0);
      tok = match_token(1, 1, 18);
      send_byte(tok[15:8], 1'b0);
      send_byte(tok[7:0], 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h3C, 1'b0);

      // A copy running past the configured length is cut short.
      write_length(24'd3);
      send_byte(8'h01, 1'b1);
      send_byte(8'hA5, 1'b0);
      tok = match_token(1, 1, 18);
      send_byte(tok[15:8], 1'b0);
      send_byte(tok[7:0], 1'b0);

      // Lowering the length below the count mid-entry ends it on the next byte.
      write_length(24'd40);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b0);
      write_length(24'd2);
      send_byte(8'h44, 1'b0);

      write_length(24'd1);
      send_byte(8'h01, 1'b1);
      send_byte(8'h80, 1'b0);

      mark = stream_bytes;
      for (p = 0; p < 4; p++) begin
         case (p)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 49; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 49; end
            default: begin gap_pct = 23; stall_pct = 23; end
         endcase
         while (stream_bytes < mark + (p + 1) * RANDOM_ITEMS / 4) begin
            if ($urandom_range(99) < 35) begin
               pick = $urandom_range(99);
               if (pick < 5) begin
                  new_len = '0;
               end else if (pick < 10) begin
                  new_len = '1;
               end else if (pick < 20) begin
                  new_len = 24'd1;
               end else begin
                  new_len = LEN_BITS'($urandom_range(2, 80));
               end
               write_length(new_len);
            end
            if ($urandom_range(99) < 85) begin
               send_entry($urandom_range(1, 4), 6, $urandom_range(20, 80), 15);
            end else begin
               repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(99) < 30);
            end
         end
      end

      // One longer entry so that copies reach well back into the history window.
      write_length('1);
      send_entry(10, 0, 10, 80);

      req_valid <= 1'b0;
      settle();
      $display("Sent %0d compressed bytes over %0d entries; %0d decoded bytes checked.",
               stream_bytes, entry_starts, bytes_seen);
      $display("Pacing: free, sender gaps, receiver stalls, both; copies reached back %0d bytes.",
               widest_reach);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: no request, result or register write accepted for %0d cycles.", $time, quiet);
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lzss_pkg.sv
rtl/lzss_history_ram.sv
rtl/lzss_rsp_stage.sv
rtl/lzss_token_ctrl.sv
rtl/lzss_decompressor_unit.sv
rtl/lzss_checker.sv
verif/lzss_decompressor_unit_checker.sv
verif/lzss_decompressor_unit_test.sv
